// ===== hdl/dsbs_pkg.sv =====
`default_nettype none

package dsbs_pkg;

   // command codes carried in the low bits of req_tdata
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_SORT   = 2'd2;
   localparam logic [1:0] CMD_SEARCH = 2'd3;

   // field widths
   localparam int KEY_W      = 8;
   localparam int PAYLOAD_W  = 16;
   localparam int SLOT_W     = 4;
   localparam int CHOICE_W   = 5;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // one table record as stored in the memory
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [KEY_W-1:0]     key;
   } record_type;

   // microprogram step addresses
   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_READ,
      S_HIT,
      S_MISS,
      S_SORT,
      S_OUTER,
      S_GRAB,
      S_SCAN,
      S_SWAP_RD,
      S_SWAP_I,
      S_SWAP_B,
      S_SRCH,
      S_PROBE,
      S_CMP,
      S_DONE
   } step_type;

   // branch conditions
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_DISPATCH,
      C_CHOICE_BAD,
      C_I_END,
      C_J_END,
      C_LOW_GT_HIGH,
      C_KEY_EQ,
      C_OUT_BUSY
   } cond_type;

   // memory read address select
   typedef enum logic [2:0] {
      A_CHOICE,
      A_I,
      A_J,
      A_JNEXT,
      A_BEST,
      A_MID
   } addr_type;

   // memory write select
   typedef enum logic [1:0] {
      W_NONE,
      W_LOAD,
      W_I_RD,
      W_BEST_TMP
   } wsel_type;

   // datapath register operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_SORT_INIT,
      OP_OUTER,
      OP_GRAB,
      OP_SCAN,
      OP_NEXT_I,
      OP_SRCH_INIT,
      OP_NARROW,
      OP_HIT,
      OP_MISS,
      OP_PUSH
   } op_type;

   // one control word
   typedef struct packed {
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
      addr_type addr;
      logic     rd;
      wsel_type wsel;
      op_type   op;
   } ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic i_end;
      logic j_end;
      logic choice_bad;
      logic low_gt_high;
      logic key_eq;
      logic out_busy;
   } flags_type;

   function automatic ctrl_type uword(cond_type c, step_type t, step_type f, addr_type a,
                                      logic r, wsel_type w, op_type o);
      ctrl_type cw;
      cw.cond  = c;
      cw.tgt_t = t;
      cw.tgt_f = f;
      cw.addr  = a;
      cw.rd    = r;
      cw.wsel  = w;
      cw.op    = o;
      return cw;
   endfunction

   // microprogram rom
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      case (s)
         S_IDLE:    w = uword(C_DISPATCH,    S_IDLE,    S_IDLE,  A_I,      1'b0, W_NONE,
                              OP_NONE);
         S_LOAD:    w = uword(C_ALWAYS,      S_DONE,    S_DONE,  A_I,      1'b0, W_LOAD,
                              OP_NONE);
         S_READ:    w = uword(C_CHOICE_BAD,  S_MISS,    S_HIT,   A_CHOICE, 1'b1, W_NONE,
                              OP_NONE);
         S_HIT:     w = uword(C_ALWAYS,      S_DONE,    S_DONE,  A_I,      1'b0, W_NONE,
                              OP_HIT);
         S_MISS:    w = uword(C_ALWAYS,      S_DONE,    S_DONE,  A_I,      1'b0, W_NONE,
                              OP_MISS);
         S_SORT:    w = uword(C_ALWAYS,      S_OUTER,   S_OUTER, A_I,      1'b0, W_NONE,
                              OP_SORT_INIT);
         S_OUTER:   w = uword(C_I_END,       S_DONE,    S_GRAB,  A_I,      1'b1, W_NONE,
                              OP_OUTER);
         S_GRAB:    w = uword(C_ALWAYS,      S_SCAN,    S_SCAN,  A_J,      1'b1, W_NONE,
                              OP_GRAB);
         S_SCAN:    w = uword(C_J_END,       S_SWAP_RD, S_SCAN,  A_JNEXT,  1'b1, W_NONE,
                              OP_SCAN);
         S_SWAP_RD: w = uword(C_ALWAYS,      S_SWAP_I,  S_SWAP_I, A_BEST,  1'b1, W_NONE,
                              OP_NONE);
         S_SWAP_I:  w = uword(C_ALWAYS,      S_SWAP_B,  S_SWAP_B, A_I,     1'b0, W_I_RD,
                              OP_NONE);
         S_SWAP_B:  w = uword(C_ALWAYS,      S_OUTER,   S_OUTER, A_I,      1'b0, W_BEST_TMP,
                              OP_NEXT_I);
         S_SRCH:    w = uword(C_ALWAYS,      S_PROBE,   S_PROBE, A_I,      1'b0, W_NONE,
                              OP_SRCH_INIT);
         S_PROBE:   w = uword(C_LOW_GT_HIGH, S_MISS,    S_CMP,   A_MID,    1'b1, W_NONE,
                              OP_NONE);
         S_CMP:     w = uword(C_KEY_EQ,      S_HIT,     S_PROBE, A_I,      1'b0, W_NONE,
                              OP_NARROW);
         S_DONE:    w = uword(C_OUT_BUSY,    S_DONE,    S_IDLE,  A_I,      1'b0, W_NONE,
                              OP_PUSH);
         default:   w = uword(C_ALWAYS,      S_IDLE,    S_IDLE,  A_I,      1'b0, W_NONE,
                              OP_NONE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dsbs_seq.sv =====
`default_nettype none

module dsbs_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          command,
   input  dsbs_pkg::flags_type flags,
   output dsbs_pkg::ctrl_type  ctrl,
   output logic                idle
);
   import dsbs_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     take;

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // next step: conditional jump or command dispatch
   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:      take = 1'b1;
         C_DISPATCH:    take = accept;
         C_CHOICE_BAD:  take = flags.choice_bad;
         C_I_END:       take = flags.i_end;
         C_J_END:       take = flags.j_end;
         C_LOW_GT_HIGH: take = flags.low_gt_high;
         C_KEY_EQ:      take = flags.key_eq;
         C_OUT_BUSY:    take = flags.out_busy;
         default:       take = 1'b1;
      endcase
      if (ctrl.cond == C_DISPATCH) begin
         if (accept) begin
            case (command)
               CMD_LOAD:   pc_in = S_LOAD;
               CMD_READ:   pc_in = S_READ;
               CMD_SORT:   pc_in = S_SORT;
               CMD_SEARCH: pc_in = S_SRCH;
               default:    pc_in = S_IDLE;
            endcase
         end else begin
            pc_in = ctrl.tgt_f;
         end
      end else begin
         pc_in = take ? ctrl.tgt_t : ctrl.tgt_f;
      end
   end

   // control word lookup
   always_comb begin
      ctrl = ucode(pc_ff);
      idle = (pc_ff == S_IDLE);
   end

endmodule

`default_nettype wire

// ===== hdl/descending_sort_and_binary_search_core.sv =====
// Record table of TABLE_DEPTH entries (8-bit key, 16-bit payload) with
// load, read, descending selection sort and binary search commands.
// Commands arrive on the req_ stream, one transfer per command; each
// command yields exactly one transfer on the rsp_ stream. csr_wr_en writes
// entry_count (entries used by read, sort and search, saturating at the
// depth); write it only while the block is idle.
// The next request is taken once the sequencer is back in its idle step,
// which follows the step that loads the response. The single memory
// read port gives one sort compare per cycle, and a swap takes three
// steps (read best, write slot i, write best slot).
// The response sits in an output register, so the next command runs while
// an unread response is held; a command only waits at its end if the
// receiver still stalls the earlier response.
// Synchronous reset clears the sequencer, the response valid and
// entry_count; table contents are undefined until loaded.
`default_nettype none

module descending_sort_and_binary_search_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // command, slot, choice, key, payload (from bit 0 up)
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dsbs_pkg::REQ_DATA_W-1:0] req_tdata,
   // status, found_slot, found_key, found_payload (from bit 0 up)
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dsbs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [dsbs_pkg::COUNT_W-1:0]    csr_wr_data
);
   import dsbs_pkg::*;

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
   localparam int CW      = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   ctrl_type  ctrl;
   flags_type flags;
   logic      idle;
   logic      req_accept;

   logic [COUNT_W-1:0]   entry_count_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [CHOICE_W-1:0]  choice_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   logic [CW-1:0]        n_used;
   logic [CW-1:0]        count_ext;
   logic [CW-1:0]        choice_ext;
   logic [CW-1:0]        choice_m1;
   logic [CW-1:0]        slot_ext;
   logic [CW-1:0]        hit_ext;
   logic [CW-1:0]        j_next;
   logic [CW+1:0]        mid_sum;
   logic [CW:0]          mid_w;

   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [KEY_W-1:0]     bkey_ff, bkey_in;
   record_type           tmp_ff, tmp_in;
   logic signed [CW:0]   low_ff, low_in;
   logic signed [CW:0]   high_ff, high_in;

   logic                 res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [KEY_W-1:0]     res_key_ff, res_key_in;
   logic [PAYLOAD_W-1:0] res_payload_ff, res_payload_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   record_type           records_ff [TABLE_DEPTH];
   record_type           rd_data_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   record_type           wr_data;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = idle;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // microcode sequencer
   dsbs_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .command (req_tdata[1:0]),
      .flags   (flags),
      .ctrl    (ctrl),
      .idle    (idle)
   );

   // entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // command fields captured on a request transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff    <= req_tdata[5:2];
         choice_ff  <= req_tdata[10:6];
         key_ff     <= req_tdata[18:11];
         payload_ff <= req_tdata[34:19];
      end
   end

   // used count, indexes and search midpoint
   always_comb begin
      count_ext  = CW'(entry_count_ff);
      n_used     = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;
      choice_ext = CW'(choice_ff);
      choice_m1  = choice_ext - CW'(1);
      slot_ext   = CW'(slot_ff);
      hit_ext    = CW'(hit_idx_ff);
      j_next     = j_ff + CW'(1);
      mid_sum    = {1'b0, low_ff} + {1'b0, high_ff};
      mid_w      = mid_sum[CW+1:1];
   end

   // status flags for the sequencer
   always_comb begin
      flags.i_end       = (i_ff >= n_used);
      flags.j_end       = (j_ff >= n_used);
      flags.choice_bad  = (choice_ext == '0) || (choice_ext > n_used);
      flags.low_gt_high = (low_ff > high_ff);
      flags.key_eq      = (rd_data_ff.key == key_ff);
      flags.out_busy    = rsp_tvalid_ff && !rsp_tready;
   end

   // memory read address
   always_comb begin
      case (ctrl.addr)
         A_CHOICE: rd_addr = choice_m1[IDX_W-1:0];
         A_I:      rd_addr = i_ff[IDX_W-1:0];
         A_J:      rd_addr = j_ff[IDX_W-1:0];
         A_JNEXT:  rd_addr = j_next[IDX_W-1:0];
         A_BEST:   rd_addr = best_ff;
         A_MID:    rd_addr = mid_w[IDX_W-1:0];
         default:  rd_addr = '0;
      endcase
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff[IDX_W-1:0];
      wr_data = rd_data_ff;
      case (ctrl.wsel)
         W_LOAD: begin
            wr_en           = (slot_ext < DEPTH_C);
            wr_addr         = slot_ext[IDX_W-1:0];
            wr_data.key     = key_ff;
            wr_data.payload = payload_ff;
         end
         W_I_RD: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
         end
         W_BEST_TMP: begin
            wr_en   = 1'b1;
            wr_addr = best_ff;
            wr_data = tmp_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // record memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         records_ff[wr_addr] <= wr_data;
      end
      if (ctrl.rd) begin
         rd_data_ff <= records_ff[rd_addr];
         hit_idx_ff <= rd_addr;
      end
   end

   // datapath register updates from the control word
   always_comb begin
      i_in           = i_ff;
      j_in           = j_ff;
      best_in        = best_ff;
      bkey_in        = bkey_ff;
      tmp_in         = tmp_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_key_in     = res_key_ff;
      res_payload_in = res_payload_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_data_in    = rsp_data_ff;

      // response taken by the receiver
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      // new command starts with a cleared result
      if (req_accept) begin
         res_status_in  = 1'b0;
         res_slot_in    = '0;
         res_key_in     = '0;
         res_payload_in = '0;
      end

      case (ctrl.op)
         OP_SORT_INIT: begin
            i_in = '0;
         end
         OP_OUTER: begin
            best_in = i_ff[IDX_W-1:0];
            j_in    = i_ff + CW'(1);
         end
         OP_GRAB: begin
            bkey_in = rd_data_ff.key;
            tmp_in  = rd_data_ff;
         end
         OP_SCAN: begin
            // first strict maximum wins
            if (!flags.j_end) begin
               if (rd_data_ff.key > bkey_ff) begin
                  best_in = j_ff[IDX_W-1:0];
                  bkey_in = rd_data_ff.key;
               end
               j_in = j_next;
            end
         end
         OP_NEXT_I: begin
            i_in = i_ff + CW'(1);
         end
         OP_SRCH_INIT: begin
            low_in  = '0;
            high_in = $signed({1'b0, n_used} - (CW+1)'(1));
         end
         OP_NARROW: begin
            // table is descending: smaller key means look lower
            if (!flags.key_eq) begin
               if (rd_data_ff.key < key_ff) begin
                  high_in = $signed(mid_w - (CW+1)'(1));
               end else begin
                  low_in = $signed(mid_w + (CW+1)'(1));
               end
            end
         end
         OP_HIT: begin
            res_status_in  = 1'b0;
            res_slot_in    = hit_ext[SLOT_W-1:0];
            res_key_in     = rd_data_ff.key;
            res_payload_in = rd_data_ff.payload;
         end
         OP_MISS: begin
            res_status_in  = 1'b1;
            res_slot_in    = '0;
            res_key_in     = '0;
            res_payload_in = '0;
         end
         OP_PUSH: begin
            if (!flags.out_busy) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = RSP_DATA_W'({res_payload_ff, res_key_ff, res_slot_ff,
                                            res_status_ff});
            end
         end
         default: begin
            i_in = i_ff;
         end
      endcase
   end

   // datapath and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      i_ff           <= i_in;
      j_ff           <= j_in;
      best_ff        <= best_in;
      bkey_ff        <= bkey_in;
      tmp_ff         <= tmp_in;
      low_ff         <= low_in;
      high_ff        <= high_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_key_ff     <= res_key_in;
      res_payload_ff <= res_payload_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/dsbs_checker.sv =====
`default_nettype none

module dsbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dsbs_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset leaves no response pending and the request side open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

   // one command at a time: no back-to-back request transfers
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is running");

   // a miss carries zero slot, key and payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[28:1] == '0)
      else $error("miss response with nonzero fields");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:29] == 3'b000)
      else $error("response padding not zero");

endmodule

bind descending_sort_and_binary_search_core dsbs_checker u_dsbs_checker (.*);

`default_nettype wire
